@@ rtl/mfrf_pkg.sv @@
// Shared types and constants for the message framed receive FIFO.
package mfrf_pkg;

	localparam int DEPTH_DEFAULT   = 256;
	localparam logic [7:0] MARKER_RESET = 8'h0D;
	localparam logic [7:0] PRINT_LO     = 8'h20;
	localparam logic [7:0] PRINT_HI     = 8'h7E;
	localparam int LEVEL_W         = 9;

	typedef enum logic {
		FUNC_RECEIVE = 1'b0,
		FUNC_POP     = 1'b1
	} func_t;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
		logic       parity_error;
		logic       overrun;
	} item_t;

	typedef struct packed {
		logic [7:0]         data_byte;
		logic               data_valid;
		logic               end_of_message;
		logic               nothing_read;
		logic [LEVEL_W-1:0] fill_level;
		logic [LEVEL_W-1:0] messages_waiting;
		logic [7:0]         parity_error_count;
		logic [7:0]         overflow_error_count;
	} result_t;

endpackage

@@ rtl/mfrf_ram.sv @@
// Generic single write port, single registered read port RAM.
module mfrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mfrf_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/mfrf_core.sv @@
// Pointer, counter and result logic for the message framed receive FIFO.
module mfrf_core #(
	parameter int DEPTH = mfrf_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s1,
	input  mfrf_pkg::item_t          item_s1,
	input  logic [7:0]               end_marker,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [7:0]               mem_wdata,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  logic [7:0]               mem_rdata,
	output logic                     done_q,
	output mfrf_pkg::result_t        result_q
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	// message count is not bounded by the fill level: after end_marker
	// changes, stored old markers no longer retire it
	localparam int MSG_W = 32;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(DEPTH - 2);

	logic [IDX_W-1:0] wr_idx_q, rd_idx_q, wr_idx_d, rd_idx_d;
	logic [CNT_W-1:0] held_q, held_d;
	logic [MSG_W-1:0] msg_q, msg_d;
	logic [7:0]       perr_q, ovf_q, perr_d, ovf_d;
	logic             byp_q;
	logic [7:0]       byp_data_q;

	logic             is_rx, is_marker, room, store, pop_ok, drop;
	logic [1:0]       ovf_add;
	logic [7:0]       pop_data;
	logic             pop_eom, pop_print;
	logic [31:0]      held_wide, msg_wide;
	mfrf_pkg::result_t res_d;

	// read data arrives in the cycle after the address; a write to that address
	// in the same cycle is forwarded
	assign pop_data = byp_q ? byp_data_q : mem_rdata;

	always_comb begin
		is_rx     = valid_s1 && (item_s1.func == mfrf_pkg::FUNC_RECEIVE);
		is_marker = (item_s1.rx_byte == end_marker);
		room      = is_marker ? (held_q < FULL_CNT) : (held_q < LIMIT_CNT);
		store     = is_rx && !item_s1.parity_error && room;
		drop      = is_rx && !item_s1.parity_error && !room;
		pop_ok    = valid_s1 && (item_s1.func == mfrf_pkg::FUNC_POP)
			&& (msg_q != '0) && (held_q != '0);
		pop_eom   = (pop_data == end_marker);
		pop_print = !pop_eom && (pop_data >= mfrf_pkg::PRINT_LO)
			&& (pop_data <= mfrf_pkg::PRINT_HI);

		ovf_add = {1'b0, is_rx && item_s1.overrun} + {1'b0, drop};
		ovf_d   = ovf_q + {6'b0, ovf_add};
		perr_d  = perr_q + {7'b0, is_rx && item_s1.parity_error};

		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		held_d   = held_q;
		msg_d    = msg_q;
		if (store) begin
			wr_idx_d = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
			held_d   = held_q + 1'b1;
			if (is_marker) begin
				msg_d = msg_q + 1'b1;
			end
		end
		if (pop_ok) begin
			rd_idx_d = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
			held_d   = held_q - 1'b1;
			if (pop_eom) begin
				msg_d = msg_q - 1'b1;
			end
		end

		held_wide = 32'(held_d);
		msg_wide  = 32'(msg_d);

		res_d.data_byte            = pop_ok ? pop_data : 8'h00;
		res_d.data_valid           = pop_ok && pop_print;
		res_d.end_of_message       = pop_ok && pop_eom;
		res_d.nothing_read         = valid_s1 && (item_s1.func == mfrf_pkg::FUNC_POP)
			&& !pop_ok;
		res_d.fill_level           = held_wide[mfrf_pkg::LEVEL_W-1:0];
		res_d.messages_waiting     = msg_wide[mfrf_pkg::LEVEL_W-1:0];
		res_d.parity_error_count   = perr_d;
		res_d.overflow_error_count = ovf_d;
	end

	assign mem_we    = store;
	assign mem_waddr = wr_idx_q;
	assign mem_wdata = item_s1.rx_byte;
	assign mem_raddr = rd_idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			held_q   <= '0;
			msg_q    <= '0;
			perr_q   <= '0;
			ovf_q    <= '0;
			byp_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= valid_s1;
			byp_q  <= store && (wr_idx_q == rd_idx_d);
			if (valid_s1) begin
				wr_idx_q <= wr_idx_d;
				rd_idx_q <= rd_idx_d;
				held_q   <= held_d;
				msg_q    <= msg_d;
				perr_q   <= perr_d;
				ovf_q    <= ovf_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= item_s1.rx_byte;
		if (valid_s1) begin
			result_q <= res_d;
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL_CNT)
		else $error("held count above depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_q)
		else $error("item without result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done_q)
		else $error("result strobe without item");

	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !store && !pop_ok) |=> $stable(held_q) && $stable(msg_q))
		else $error("counts moved on an item that stores or pops nothing");

endmodule

@@ rtl/message_framed_receive_fifo_core.sv @@
// Top level of the message framed receive FIFO.
//
// Command channel: an item (func, rx_byte, parity_error, overrun) is taken
// at a rising edge with start high and busy low. busy stays low, so a new
// item may be started in every cycle: one item per cycle sustained.
// Each item yields exactly one result on the output ports, marked by done
// for a single cycle; the item is registered into valid_s1 / item_s1 and
// its result then into result_q with done. The receiver cannot stall.
// func receive stores rx_byte (or counts parity/overflow); func pop takes
// one byte only while a complete message, ended by end_marker, is held.
// end_marker is written with cfg_we / cfg_wdata while no item is in flight
// (the user must see to it; the block does not check). Byte storage is a
// DEPTH entry RAM with registered read; the read address runs one item
// ahead so popped data is ready when the pop is worked on. Asynchronous
// reset clears pointers, counts and error counters and sets end_marker to
// carriage return; the RAM is not cleared and no clearing pass is needed.
module message_framed_receive_fifo_core #(
	parameter int DEPTH = mfrf_pkg::DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       func,
	input  logic [7:0] rx_byte,
	input  logic       parity_error,
	input  logic       overrun,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output logic       done,
	output logic [7:0] data_byte,
	output logic       data_valid,
	output logic       end_of_message,
	output logic       nothing_read,
	output logic [8:0] fill_level,
	output logic [8:0] messages_waiting,
	output logic [7:0] parity_error_count,
	output logic [7:0] overflow_error_count
);

	localparam int IDX_W = $clog2(DEPTH);

	logic              valid_s1;
	mfrf_pkg::item_t   item_s1;
	logic [7:0]        end_marker_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;
	mfrf_pkg::result_t result_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			end_marker_q <= mfrf_pkg::MARKER_RESET;
		end else begin
			valid_s1 <= start && !busy;
			if (cfg_we) begin
				end_marker_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1.func         <= func;
			item_s1.rx_byte      <= rx_byte;
			item_s1.parity_error <= parity_error;
			item_s1.overrun      <= overrun;
		end
	end

	mfrf_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	mfrf_core #(
		.DEPTH(DEPTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.end_marker (end_marker_q),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.done_q     (done),
		.result_q   (result_q)
	);

	assign data_byte            = result_q.data_byte;
	assign data_valid           = result_q.data_valid;
	assign end_of_message       = result_q.end_of_message;
	assign nothing_read         = result_q.nothing_read;
	assign fill_level           = result_q.fill_level;
	assign messages_waiting     = result_q.messages_waiting;
	assign parity_error_count   = result_q.parity_error_count;
	assign overflow_error_count = result_q.overflow_error_count;

endmodule

@@ verif/message_framed_receive_fifo_core_tb.sv @@
// Self-checking testbench for the message framed receive FIFO core.
`timescale 1ns / 1ps

class rx_fifo_shadow;
	localparam int FIFO_DEPTH = mfrf_pkg::DEPTH_DEFAULT;

	logic [7:0]  bytes_held [FIFO_DEPTH];
	int unsigned wr_ptr, rd_ptr, held, msgs;
	logic [7:0]  parity_cnt, overflow_cnt, marker;
	mfrf_pkg::result_t pending_results [$];
	int unsigned faults, checked;
	int unsigned n_items, n_recv, n_drop, n_pop, n_empty_pop, n_eom, n_marker_writes;

	function void clear();
		wr_ptr = 0;
		rd_ptr = 0;
		held = 0;
		msgs = 0;
		parity_cnt = '0;
		overflow_cnt = '0;
		marker = mfrf_pkg::MARKER_RESET;
	endfunction

	function void take_item(mfrf_pkg::item_t it);
		mfrf_pkg::result_t r;
		bit is_mark, room;
		r = '0;
		n_items++;
		if (mfrf_pkg::func_t'(it.func) == mfrf_pkg::FUNC_RECEIVE) begin
			n_recv++;
			if (it.overrun)
				overflow_cnt++;
			if (it.parity_error) begin
				parity_cnt++;
			end else begin
				is_mark = (it.rx_byte == marker);
				// the marker may use the last two slots, plain bytes may not
				room = is_mark ? (held < FIFO_DEPTH) : (held < FIFO_DEPTH - 2);
				if (room) begin
					bytes_held[wr_ptr] = it.rx_byte;
					wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
					held++;
					if (is_mark)
						msgs++;
				end else begin
					overflow_cnt++;
					n_drop++;
				end
			end
		end else begin
			n_pop++;
			if (msgs > 0 && held > 0) begin
				r.data_byte = bytes_held[rd_ptr];
				rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
				held--;
				if (r.data_byte == marker) begin
					r.end_of_message = 1'b1;
					msgs--;
					n_eom++;
				end else if (r.data_byte >= mfrf_pkg::PRINT_LO
					&& r.data_byte <= mfrf_pkg::PRINT_HI) begin
					r.data_valid = 1'b1;
				end
			end else begin
				r.nothing_read = 1'b1;
				n_empty_pop++;
			end
		end
		r.fill_level = held[mfrf_pkg::LEVEL_W-1:0];
		r.messages_waiting = msgs[mfrf_pkg::LEVEL_W-1:0];
		r.parity_error_count = parity_cnt;
		r.overflow_error_count = overflow_cnt;
		pending_results.push_back(r);
	endfunction

	function void compare(string field, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			faults++;
			if (faults <= 10)
				$display("%0t: result %0d field %s: expected 0x%0h, got 0x%0h",
					$realtime, checked, field, want, got);
		end
	endfunction

	function void match_result(mfrf_pkg::result_t got);
		mfrf_pkg::result_t want;
		if (pending_results.size() == 0) begin
			faults++;
			if (faults <= 10)
				$display("%0t: result with nothing expected: 0x%0h", $realtime, got);
			return;
		end
		want = pending_results.pop_front();
		checked++;
		compare("data_byte", want.data_byte, got.data_byte);
		compare("data_valid", want.data_valid, got.data_valid);
		compare("end_of_message", want.end_of_message, got.end_of_message);
		compare("nothing_read", want.nothing_read, got.nothing_read);
		compare("fill_level", want.fill_level, got.fill_level);
		compare("messages_waiting", want.messages_waiting, got.messages_waiting);
		compare("parity_error_count", want.parity_error_count, got.parity_error_count);
		compare("overflow_error_count", want.overflow_error_count,
			got.overflow_error_count);
	endfunction
endclass

module message_framed_receive_fifo_core_tb;

	localparam int FIFO_DEPTH   = mfrf_pkg::DEPTH_DEFAULT;
	localparam int ITEM_TARGET  = 1300;
	localparam int CYCLE_LIMIT  = 400000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       func;
	logic [7:0] rx_byte;
	logic       parity_error;
	logic       overrun;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       done;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       end_of_message;
	logic       nothing_read;
	logic [8:0] fill_level;
	logic [8:0] messages_waiting;
	logic [7:0] parity_error_count;
	logic [7:0] overflow_error_count;

	rx_fifo_shadow     shadow;
	mfrf_pkg::result_t observed;
	bit                sender_idles;

	message_framed_receive_fifo_core dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.func                (func),
		.rx_byte             (rx_byte),
		.parity_error        (parity_error),
		.overrun             (overrun),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.done                (done),
		.data_byte           (data_byte),
		.data_valid          (data_valid),
		.end_of_message      (end_of_message),
		.nothing_read        (nothing_read),
		.fill_level          (fill_level),
		.messages_waiting    (messages_waiting),
		.parity_error_count  (parity_error_count),
		.overflow_error_count(overflow_error_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			observed = {data_byte, data_valid, end_of_message, nothing_read, fill_level,
				messages_waiting, parity_error_count, overflow_error_count};
			shadow.match_result(observed);
		end
	end

	task automatic drive_item(input mfrf_pkg::item_t it);
		int gap;
		gap = sender_idles ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= it.func;
		rx_byte <= it.rx_byte;
		parity_error <= it.parity_error;
		overrun <= it.overrun;
		do @(posedge clk); while (busy);
		shadow.take_item(it);
	endtask

	task automatic recv(input logic [7:0] b, input logic pe, input logic ov);
		mfrf_pkg::item_t it;
		it.func = mfrf_pkg::FUNC_RECEIVE;
		it.rx_byte = b;
		it.parity_error = pe;
		it.overrun = ov;
		drive_item(it);
	endtask

	// unused fields on a pop carry noise
	task automatic pop();
		mfrf_pkg::item_t it;
		it.func = mfrf_pkg::FUNC_POP;
		it.rx_byte = 8'($urandom_range(0, 255));
		it.parity_error = 1'($urandom_range(0, 1));
		it.overrun = 1'($urandom_range(0, 1));
		drive_item(it);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h1E, 8'h80))
			: 8'($urandom_range(0, 255));
		if (b == shadow.marker)
			b = b ^ 8'h01;
		return b;
	endfunction

	// sender holds off until every result is back
	task automatic settle();
		start <= 1'b0;
		while (shadow.pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_marker(input logic [7:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		shadow.marker = value;
		shadow.n_marker_writes++;
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (shadow.msgs > 0 && shadow.held > 0)
			pop();
		repeat (2) pop();
	endtask

	// run the buffer into both room limits, then empty it
	task automatic fill_and_drain();
		int over;
		over = 0;
		while (over < 8) begin
			if (shadow.held >= FIFO_DEPTH - 2)
				over++;
			recv($urandom_range(0, 255) == shadow.marker ? ~shadow.marker : plain_byte(),
				$urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
		end
		repeat (3) recv(shadow.marker, 1'b0, 1'b0);
		recv(plain_byte(), 1'b0, 1'b0);
		drain();
	endtask

	task automatic message_burst();
		int n_msgs, len;
		n_msgs = $urandom_range(1, 6);
		for (int m = 0; m < n_msgs; m++) begin
			if (shadow.held > 200)
				drain();
			len = $urandom_range(0, 15);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) < 3)
					pop();
				recv(plain_byte(), $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
			end
			recv(shadow.marker, $urandom_range(0, 15) == 0, $urandom_range(0, 11) == 0);
		end
	endtask

	task automatic noise_burst();
		int n;
		n = $urandom_range(20, 60);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				pop();
			else
				recv($urandom_range(0, 7) == 0 ? shadow.marker : 8'($urandom_range(0, 255)),
					$urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic random_marker();
		case ($urandom_range(0, 5))
			0: write_marker(8'h00);
			1: write_marker(8'hFF);
			2: write_marker(mfrf_pkg::MARKER_RESET);
			3: write_marker(mfrf_pkg::PRINT_LO);
			4: write_marker(mfrf_pkg::PRINT_HI);
			default: write_marker(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic random_phases(input int unsigned until_items);
		int mode;
		while (shadow.n_items < until_items) begin
			sender_idles = ($urandom_range(0, 2) != 0);
			mode = $urandom_range(0, 9);
			if (mode <= 4)
				message_burst();
			else if (mode == 5)
				drain();
			else if (mode <= 7)
				noise_burst();
			else if (mode == 8)
				random_marker();
			else
				settle();
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("message_framed_receive_fifo_core verification failed");
		$finish;
	end

	initial begin
		int waited;
		shadow = new;
		shadow.clear();
		arst_n = 1'b0;
		start = 1'b0;
		func = mfrf_pkg::FUNC_RECEIVE;
		rx_byte = '0;
		parity_error = 1'b0;
		overrun = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sender_idles = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: printable bounds, flags, pop before a message is complete
		pop();
		recv(8'h20, 1'b0, 1'b0);
		recv(8'h1F, 1'b0, 1'b0);
		recv(8'h7E, 1'b0, 1'b0);
		recv(8'h7F, 1'b0, 1'b0);
		recv(8'h00, 1'b0, 1'b0);
		recv(8'hFF, 1'b0, 1'b0);
		recv(8'h41, 1'b1, 1'b0);
		recv(8'h42, 1'b0, 1'b1);
		recv(mfrf_pkg::MARKER_RESET, 1'b1, 1'b1);
		pop();
		recv(mfrf_pkg::MARKER_RESET, 1'b0, 1'b0);
		sender_idles = 1'b1;
		repeat (9) pop();
		pop();

		write_marker(8'hFF);
		sender_idles = 1'b0;
		fill_and_drain();
		random_phases(ITEM_TARGET / 2);
		write_marker(8'h00);
		sender_idles = 1'b1;
		fill_and_drain();
		random_phases(ITEM_TARGET);
		drain();

		start <= 1'b0;
		for (waited = 0; waited < 200 && shadow.pending_results.size() != 0; waited++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (shadow.pending_results.size() != 0) begin
			$display("%0d expected results never arrived", shadow.pending_results.size());
			shadow.faults += shadow.pending_results.size();
		end
		$display("covered %0d items: %0d receives (%0d dropped, buffer full), %0d pops (%0d empty)",
			shadow.n_items, shadow.n_recv, shadow.n_drop, shadow.n_pop, shadow.n_empty_pop);
		$display("%0d messages ended by marker, %0d marker writes, %0d results checked",
			shadow.n_eom, shadow.n_marker_writes, shadow.checked);
		if (shadow.faults == 0)
			$display("message_framed_receive_fifo_core verification clean");
		else
			$display("message_framed_receive_fifo_core verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mfrf_pkg.sv
rtl/mfrf_ram.sv
rtl/mfrf_core.sv
rtl/message_framed_receive_fifo_core.sv
verif/message_framed_receive_fifo_core_tb.sv
